// ===== sv/assert_macros.svh =====
// assertion macros shared by the packetizer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked property with reset disable
`define RNP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// checked property that also holds during reset
`define RNP_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define RNP_ASSERT(lbl, clk, rst, prop)
`define RNP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== sv/rnp_pkg.sv =====
// types and constants of the rtp nal packetizer
`timescale 1ns / 1ps
`default_nettype none
package rnp_pkg;

   // payload limit clamp and reset values
   localparam logic [10:0] PAY_MIN       = 11'd1100;
   localparam logic [10:0] PAY_MAX       = 11'd1460;
   localparam logic [10:0] MAXPAY_RESET  = 11'd1400;
   localparam logic [6:0]  PKIND_RESET   = 7'd96;

   // register indexes
   localparam logic [1:0] REG_CODEC  = 2'd0;
   localparam logic [1:0] REG_SSRC   = 2'd1;
   localparam logic [1:0] REG_MAXPAY = 2'd2;
   localparam logic [1:0] REG_PKIND  = 2'd3;

   // codec select values
   localparam logic CODEC_H264 = 1'b0;
   localparam logic CODEC_H265 = 1'b1;

   // fragmentation header constants
   localparam logic [7:0] FU_A_TYPE     = 8'd28;
   localparam logic [7:0] HEVC_FU_TYPE  = 8'd49;
   localparam logic [7:0] H264_NRI_MASK = 8'hE0;
   localparam logic [7:0] H264_TYPE_MASK = 8'h1F;
   localparam logic [7:0] H265_KEEP_MASK = 8'h81;
   localparam logic [7:0] H265_TYPE_MASK = 8'h3F;
   localparam logic [7:0] FLAG_START    = 8'h80;
   localparam logic [7:0] FLAG_END      = 8'h40;

   // prefix byte counts
   localparam logic [1:0] CNT_SINGLE = 2'd0;
   localparam logic [1:0] CNT_H264   = 2'd2;
   localparam logic [1:0] CNT_H265   = 2'd3;

   // 90 khz timestamp: (pts * 9) / 100
   localparam logic [6:0] TS_DIVISOR = 7'd100;
   // floor(t * TS_RECIP / 2^30) equals floor(t / 100) for any t below 2^23
   localparam logic [23:0] TS_RECIP  = 24'd10737419;

   // one classified nal unit
   typedef struct packed {
      logic        frag;
      logic [31:0] ts;
      logic        uend;
      logic [7:0]  b0;
      logic [7:0]  b1;
      logic [7:0]  b2;
      logic [1:0]  cnt;
      logic [15:0] len;
      logic [10:0] chunk_max;
   } desc_type;

   // queue occupancy flags
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage
`default_nettype wire

// ===== sv/rnp_front.sv =====
// front end: accepts nal words, derives the timestamp and classifies the unit
`timescale 1ns / 1ps
`default_nettype none
module rnp_front
   import rnp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_nal_length,
   input  wire logic [7:0]  req_nal_head0,
   input  wire logic [7:0]  req_nal_head1,
   input  wire logic        req_unit_end,
   input  wire logic [63:0] req_pts_micro,
   input  wire logic        codec,
   input  wire logic [10:0] max_pay,
   input  q_stat_type       q_stat,
   output logic             push,
   output desc_type         push_desc
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_DIV  = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [2:0]  step_ff, step_in;
   logic [63:0] num_ff, num_in;
   logic [31:0] quo_ff, quo_in;
   logic [15:0] qd_ff, qd_in;
   logic [6:0]  rem_ff, rem_in;
   logic [15:0] len_ff, len_in;
   logic [7:0]  h0_ff, h0_in;
   logic [7:0]  h1_ff, h1_in;
   logic        uend_ff, uend_in;

   logic        accept;
   logic [63:0] pts9;
   logic [22:0] digit_num;
   logic [45:0] prod;
   logic [22:0] qd_x100;
   logic [22:0] rem_full;
   logic [10:0] lim;

   assign req_stall = (state_ff != F_IDLE);
   assign accept    = req_valid && (state_ff == F_IDLE);

   // pts * 9 modulo 2^64
   assign pts9 = {req_pts_micro[60:0], 3'b000} + req_pts_micro;

   // long division by 100 in 16-bit digits, reciprocal multiply per digit
   assign digit_num = {rem_ff, num_ff[63:48]};
   assign prod      = {23'd0, digit_num} * {22'd0, TS_RECIP};
   assign qd_x100   = {7'd0, qd_ff} * {16'd0, TS_DIVISOR};
   assign rem_full  = digit_num - qd_x100;

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      qd_in    = qd_ff;
      rem_in   = rem_ff;
      len_in   = len_ff;
      h0_in    = h0_ff;
      h1_in    = h1_ff;
      uend_in  = uend_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               num_in   = pts9;
               rem_in   = '0;
               step_in  = '0;
               len_in   = req_nal_length;
               h0_in    = req_nal_head0;
               h1_in    = req_nal_head1;
               uend_in  = req_unit_end;
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            step_in = step_ff + 3'd1;
            if (!step_ff[0]) begin
               // quotient digit from the reciprocal product
               qd_in = prod[45:30];
            end else begin
               // remainder and shift to the next digit
               rem_in = rem_full[6:0];
               quo_in = {quo_ff[15:0], qd_ff};
               num_in = {num_ff[47:0], 16'd0};
               if (step_ff == 3'd7) begin
                  state_in = F_PUSH;
               end
            end
         end
         F_PUSH: begin
            if (len_ff == 16'd0 || !q_stat.full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      qd_ff   <= qd_in;
      rem_ff  <= rem_in;
      len_ff  <= len_in;
      h0_ff   <= h0_in;
      h1_ff   <= h1_in;
      uend_ff <= uend_in;
   end

   // clamp the payload limit
   always_comb begin
      priority if (max_pay < PAY_MIN) begin
         lim = PAY_MIN;
      end else if (max_pay > PAY_MAX) begin
         lim = PAY_MAX;
      end else begin
         lim = max_pay;
      end
   end

   // classify the unit; zero-length units are dropped
   assign push = (state_ff == F_PUSH) && (len_ff != 16'd0) && !q_stat.full;

   always_comb begin
      push_desc      = '0;
      push_desc.ts   = quo_ff;
      push_desc.uend = uend_ff;
      push_desc.len  = len_ff;
      push_desc.frag = (len_ff > {5'b0, lim});
      if (!push_desc.frag) begin
         push_desc.cnt = CNT_SINGLE;
      end else if (codec == CODEC_H264) begin
         push_desc.b0        = (h0_ff & H264_NRI_MASK) | FU_A_TYPE;
         push_desc.b1        = h0_ff & H264_TYPE_MASK;
         push_desc.b2        = 8'd0;
         push_desc.cnt       = CNT_H264;
         push_desc.chunk_max = lim - 11'd2;
      end else begin
         push_desc.b0        = (h0_ff & H265_KEEP_MASK) | {HEVC_FU_TYPE[6:0], 1'b0};
         push_desc.b1        = h1_ff;
         push_desc.b2        = {1'b0, h0_ff[7:1]} & H265_TYPE_MASK;
         push_desc.cnt       = CNT_H265;
         push_desc.chunk_max = lim - 11'd3;
      end
   end

endmodule
`default_nettype wire

// ===== sv/rnp_queue.sv =====
// two-entry descriptor queue between front and back
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rnp_queue
   import rnp_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  desc_type  push_desc,
   input  wire logic pop,
   output desc_type  head_desc,
   output q_stat_type q_stat
);

   desc_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign q_stat.full  = (count_ff == 2'd2);
   assign q_stat.empty = (count_ff == 2'd0);
   assign head_desc    = slot_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

   `RNP_ASSERT(a_no_overflow, clock, reset, push |-> !q_stat.full)
   `RNP_ASSERT(a_no_underflow, clock, reset, pop |-> !q_stat.empty)
   `RNP_ASSERT(a_count_bound, clock, reset, count_ff != 2'd3)

endmodule
`default_nettype wire

// ===== sv/rnp_back.sv =====
// back end: walks a unit and emits one packet word per cycle while the output is not stalled
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rnp_back
   import rnp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  desc_type         head_desc,
   input  q_stat_type       q_stat,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_seq_num,
   output logic [31:0]      rsp_rtp_time,
   output logic             rsp_marker_bit,
   output logic             rsp_is_fragment,
   output logic [7:0]       rsp_prefix_byte0,
   output logic [7:0]       rsp_prefix_byte1,
   output logic [7:0]       rsp_prefix_byte2,
   output logic [1:0]       rsp_prefix_count,
   output logic [15:0]      rsp_payload_start,
   output logic [10:0]      rsp_payload_bytes,
   output logic             rsp_last_packet
);

   typedef enum logic [1:0] {
      B_IDLE = 2'b01,
      B_RUN  = 2'b10
   } back_state_type;

   back_state_type state_ff, state_in;
   desc_type    cur_ff, cur_in;
   logic [15:0] off_ff, off_in;
   logic        first_ff, first_in;
   logic [15:0] seq_ff, seq_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [15:0] seq_out_ff, seq_out_in;
   logic [31:0] time_ff, time_in;
   logic        marker_ff, marker_in;
   logic        frag_ff, frag_in;
   logic [7:0]  pb0_ff, pb0_in;
   logic [7:0]  pb1_ff, pb1_in;
   logic [7:0]  pb2_ff, pb2_in;
   logic [1:0]  pcnt_ff, pcnt_in;
   logic [15:0] start_ff, start_in;
   logic [10:0] bytes_ff, bytes_in;
   logic        last_ff, last_in;

   logic        out_free;
   logic        emit;
   logic [15:0] remain;
   logic        fits;
   logic [10:0] chunk;
   logic        pkt_end;
   logic [7:0]  flags;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = (state_ff == B_RUN) && out_free;
   assign pop      = (state_ff == B_IDLE) && !q_stat.empty;

   // size of the next packet
   assign remain  = cur_ff.len - off_ff;
   assign fits    = (remain <= {5'b0, cur_ff.chunk_max});
   assign chunk   = !cur_ff.frag ? cur_ff.len[10:0] :
                    (fits ? remain[10:0] : cur_ff.chunk_max);
   assign pkt_end = !cur_ff.frag || fits;
   assign flags   = (first_ff ? FLAG_START : 8'd0) | (pkt_end ? FLAG_END : 8'd0);

   // unit walker
   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      off_in   = off_ff;
      first_in = first_ff;
      seq_in   = seq_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (pop) begin
               cur_in   = head_desc;
               off_in   = head_desc.frag ? ({14'd0, head_desc.cnt} - 16'd1) : 16'd0;
               first_in = 1'b1;
               state_in = B_RUN;
            end
         end
         B_RUN: begin
            if (out_free) begin
               off_in   = off_ff + {5'd0, chunk};
               first_in = 1'b0;
               seq_in   = seq_ff + 16'd1;
               if (pkt_end) begin
                  state_in = B_IDLE;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = out_free ? emit : rsp_valid_ff;
      seq_out_in   = seq_out_ff;
      time_in      = time_ff;
      marker_in    = marker_ff;
      frag_in      = frag_ff;
      pb0_in       = pb0_ff;
      pb1_in       = pb1_ff;
      pb2_in       = pb2_ff;
      pcnt_in      = pcnt_ff;
      start_in     = start_ff;
      bytes_in     = bytes_ff;
      last_in      = last_ff;
      if (emit) begin
         seq_out_in = seq_ff;
         time_in    = cur_ff.ts;
         marker_in  = pkt_end && cur_ff.uend;
         frag_in    = cur_ff.frag;
         start_in   = off_ff;
         bytes_in   = chunk;
         last_in    = pkt_end;
         if (!cur_ff.frag) begin
            pb0_in  = 8'd0;
            pb1_in  = 8'd0;
            pb2_in  = 8'd0;
            pcnt_in = CNT_SINGLE;
         end else if (cur_ff.cnt == CNT_H264) begin
            pb0_in  = cur_ff.b0;
            pb1_in  = cur_ff.b1 | flags;
            pb2_in  = 8'd0;
            pcnt_in = CNT_H264;
         end else begin
            pb0_in  = cur_ff.b0;
            pb1_in  = cur_ff.b1;
            pb2_in  = cur_ff.b2 | flags;
            pcnt_in = CNT_H265;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         seq_ff       <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff     <= cur_in;
      off_ff     <= off_in;
      first_ff   <= first_in;
      seq_out_ff <= seq_out_in;
      time_ff    <= time_in;
      marker_ff  <= marker_in;
      frag_ff    <= frag_in;
      pb0_ff     <= pb0_in;
      pb1_ff     <= pb1_in;
      pb2_ff     <= pb2_in;
      pcnt_ff    <= pcnt_in;
      start_ff   <= start_in;
      bytes_ff   <= bytes_in;
      last_ff    <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_seq_num       = seq_out_ff;
   assign rsp_rtp_time      = time_ff;
   assign rsp_marker_bit    = marker_ff;
   assign rsp_is_fragment   = frag_ff;
   assign rsp_prefix_byte0  = pb0_ff;
   assign rsp_prefix_byte1  = pb1_ff;
   assign rsp_prefix_byte2  = pb2_ff;
   assign rsp_prefix_count  = pcnt_ff;
   assign rsp_payload_start = start_ff;
   assign rsp_payload_bytes = bytes_ff;
   assign rsp_last_packet   = last_ff;

   `RNP_ASSERT(a_off_in_range, clock, reset, (state_ff == B_RUN && cur_ff.frag) |-> off_ff < cur_ff.len)
   `RNP_ASSERT(a_bytes_nonzero, clock, reset, rsp_valid_ff |-> bytes_ff != 11'd0)
   `RNP_ASSERT(a_marker_on_last, clock, reset, (rsp_valid_ff && marker_ff) |-> last_ff)

endmodule
`default_nettype wire

// ===== sv/rtp_h26x_nal_packetizer.sv =====
// top level of the rtp h.264 / h.265 nal packetizer
`timescale 1ns / 1ps
`default_nettype none
// Turns one NAL unit word into RTP packet words: a single-NAL packet when the
// unit fits the payload limit, else FU-A (H.264) or FU (H.265) fragments, each
// with sequence number, 90 kHz timestamp, marker, prefix bytes, payload offset
// and length. The front end accepts a unit, divides pts*9 by 100 as four
// 16-bit digits and hands the unit to the queue; it stalls requests until
// it is idle again, so it takes no new unit before the last is handed on.
// The back end loads a unit from the queue, then sends one packet word per
// cycle while the output is not stalled, up to 60 words per unit; a two-entry
// queue lets the front work on the next unit while packets drain.
// Configuration: byte address 0 codec select, 4 SSRC, 8 payload limit,
// 12 payload type; write only while no unit is in flight.
module rtp_h26x_nal_packetizer
   import rnp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_nal_length,
   input  wire logic [7:0]  req_nal_head0,
   input  wire logic [7:0]  req_nal_head1,
   input  wire logic        req_unit_end,
   input  wire logic [63:0] req_pts_micro,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_seq_num,
   output logic [31:0]      rsp_rtp_time,
   output logic             rsp_marker_bit,
   output logic             rsp_is_fragment,
   output logic [7:0]       rsp_prefix_byte0,
   output logic [7:0]       rsp_prefix_byte1,
   output logic [7:0]       rsp_prefix_byte2,
   output logic [1:0]       rsp_prefix_count,
   output logic [15:0]      rsp_payload_start,
   output logic [10:0]      rsp_payload_bytes,
   output logic             rsp_last_packet,
   // configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic        codec_ff;
   logic [31:0] ssrc_ff;
   logic [10:0] maxpay_ff;
   logic [6:0]  pkind_ff;
   logic        csr_wr;
   logic [1:0]  csr_idx;

   logic       push;
   logic       pop;
   desc_type   push_desc;
   desc_type   head_desc;
   q_stat_type q_stat;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         codec_ff  <= CODEC_H264;
         ssrc_ff   <= 32'd0;
         maxpay_ff <= MAXPAY_RESET;
         pkind_ff  <= PKIND_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_CODEC:  codec_ff  <= csr_pwdata[0];
            REG_SSRC:   ssrc_ff   <= csr_pwdata;
            REG_MAXPAY: maxpay_ff <= csr_pwdata[10:0];
            REG_PKIND:  pkind_ff  <= csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (csr_idx)
         REG_CODEC:  csr_prdata = {31'd0, codec_ff};
         REG_SSRC:   csr_prdata = ssrc_ff;
         REG_MAXPAY: csr_prdata = {21'd0, maxpay_ff};
         REG_PKIND:  csr_prdata = {25'd0, pkind_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   rnp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_nal_length (req_nal_length),
      .req_nal_head0  (req_nal_head0),
      .req_nal_head1  (req_nal_head1),
      .req_unit_end   (req_unit_end),
      .req_pts_micro  (req_pts_micro),
      .codec          (codec_ff),
      .max_pay        (maxpay_ff),
      .q_stat         (q_stat),
      .push           (push),
      .push_desc      (push_desc)
   );

   rnp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .q_stat    (q_stat)
   );

   rnp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_desc         (head_desc),
      .q_stat            (q_stat),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_seq_num       (rsp_seq_num),
      .rsp_rtp_time      (rsp_rtp_time),
      .rsp_marker_bit    (rsp_marker_bit),
      .rsp_is_fragment   (rsp_is_fragment),
      .rsp_prefix_byte0  (rsp_prefix_byte0),
      .rsp_prefix_byte1  (rsp_prefix_byte1),
      .rsp_prefix_byte2  (rsp_prefix_byte2),
      .rsp_prefix_count  (rsp_prefix_count),
      .rsp_payload_start (rsp_payload_start),
      .rsp_payload_bytes (rsp_payload_bytes),
      .rsp_last_packet   (rsp_last_packet)
   );

endmodule
`default_nettype wire
